// File: design/lswa_pkg.sv
`default_nettype none

package lswa_pkg;

	localparam int LED_COUNT = 18;
	localparam int LED_W     = 5;
	localparam int DIV_BITS  = 14;
	localparam int STEP_W    = 4;
	localparam int OP_W      = 4;

	localparam logic [LED_W-1:0] LED_LAST = LED_W'(LED_COUNT - 1);

	// configuration register indexes
	localparam logic [1:0] CFG_PHASE_STEP   = 2'd0;
	localparam logic [1:0] CFG_PHASE_PERIOD = 2'd1;
	localparam logic [1:0] CFG_WAVE_WIDTH   = 2'd2;
	localparam logic [1:0] CFG_INV_WIDTH    = 2'd3;

	// datapath operations
	localparam logic [OP_W-1:0] OP_IDLE      = 4'd0;
	localparam logic [OP_W-1:0] OP_DIV       = 4'd1;
	localparam logic [OP_W-1:0] OP_FIX       = 4'd2;
	localparam logic [OP_W-1:0] OP_MUL_RATIO = 4'd3;
	localparam logic [OP_W-1:0] OP_RATIO     = 4'd4;
	localparam logic [OP_W-1:0] OP_DIFF      = 4'd5;
	localparam logic [OP_W-1:0] OP_MUL_DIFF  = 4'd6;
	localparam logic [OP_W-1:0] OP_INTEN     = 4'd7;
	localparam logic [OP_W-1:0] OP_MUL_SCALE = 4'd8;
	localparam logic [OP_W-1:0] OP_SCALE     = 4'd9;
	localparam logic [OP_W-1:0] OP_MUL_CH    = 4'd10;
	localparam logic [OP_W-1:0] OP_EMIT      = 4'd11;

	// jump conditions
	localparam logic [1:0] JMP_NEXT = 2'd0;
	localparam logic [1:0] JMP_TICK = 2'd1;
	localparam logic [1:0] JMP_DIV  = 2'd2;
	localparam logic [1:0] JMP_EMIT = 2'd3;

	localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
	localparam logic [STEP_W-1:0] STEP_DIV      = 4'd1;
	localparam logic [STEP_W-1:0] STEP_LED_LOOP = 4'd5;

	typedef struct packed {
		logic              in_ready;
		logic [OP_W-1:0]   op;
		logic [1:0]        jmp;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t w;
		w = '{in_ready: 1'b0, op: OP_IDLE, jmp: JMP_NEXT, target: STEP_IDLE};
		unique case (step)
			4'd0:  w = '{in_ready: 1'b1, op: OP_IDLE,      jmp: JMP_TICK, target: STEP_IDLE};
			4'd1:  w = '{in_ready: 1'b0, op: OP_DIV,       jmp: JMP_DIV,  target: STEP_DIV};
			4'd2:  w = '{in_ready: 1'b0, op: OP_FIX,       jmp: JMP_NEXT, target: STEP_IDLE};
			4'd3:  w = '{in_ready: 1'b0, op: OP_MUL_RATIO, jmp: JMP_NEXT, target: STEP_IDLE};
			4'd4:  w = '{in_ready: 1'b0, op: OP_RATIO,     jmp: JMP_NEXT, target: STEP_IDLE};
			4'd5:  w = '{in_ready: 1'b0, op: OP_DIFF,      jmp: JMP_NEXT, target: STEP_IDLE};
			4'd6:  w = '{in_ready: 1'b0, op: OP_MUL_DIFF,  jmp: JMP_NEXT, target: STEP_IDLE};
			4'd7:  w = '{in_ready: 1'b0, op: OP_INTEN,     jmp: JMP_NEXT, target: STEP_IDLE};
			4'd8:  w = '{in_ready: 1'b0, op: OP_MUL_SCALE, jmp: JMP_NEXT, target: STEP_IDLE};
			4'd9:  w = '{in_ready: 1'b0, op: OP_SCALE,     jmp: JMP_NEXT, target: STEP_IDLE};
			4'd10: w = '{in_ready: 1'b0, op: OP_MUL_CH,    jmp: JMP_NEXT, target: STEP_IDLE};
			4'd11: w = '{in_ready: 1'b0, op: OP_EMIT,      jmp: JMP_EMIT, target: STEP_LED_LOOP};
			default: w = '{in_ready: 1'b0, op: OP_IDLE,    jmp: JMP_NEXT, target: STEP_IDLE};
		endcase
		return w;
	endfunction

	// distance of an led to its segment centre, q8
	function automatic logic [9:0] led_dist(input logic [LED_W-1:0] idx);
		logic [12:0] pos;
		logic [12:0] centre;
		logic [12:0] d;
		pos = {idx, 8'd0};
		if (idx < 5'd5) begin
			centre = 13'd128;
		end else if (idx > 5'd12) begin
			centre = 13'd4224;
		end else begin
			centre = 13'd2176;
		end
		d = (pos >= centre) ? pos - centre : centre - pos;
		return d[9:0];
	endfunction

	function automatic logic led_white(input logic [LED_W-1:0] idx);
		return (idx >= 5'd5) && (idx <= 5'd12);
	endfunction

endpackage

`default_nettype wire

// File: design/led_strip_wave_animator.sv
// led strip wave animator
// input stream: one beat per animation frame, tdata bit 0 is the tick flag.
// a beat with tick low is taken and dropped. a beat with tick high advances
// the phase by phase_step, wraps it into [0, phase_period) and produces 18
// output beats, led 0 first, tlast on led 17.
// the config channel writes phase_step, phase_period, wave_width and
// inv_wave_width by index 0..3; it is always ready and must only be used
// while no frame is in flight.
// control is a 12-word microcode rom stepped once per cycle, unless it waits
// for a tick or holds on its emit word, over a single 17x17 multiplier. a
// frame runs a bit-serial wrap of the 14-bit phase magnitude, the setup steps
// fix, ratio multiply and ratio, then the led loop from diff to emit per led.
// results leave through an output register; when it is still full the
// sequencer holds on its emit word until the beat is taken. the input is
// only ready between frames.
// reset loads the register defaults and sets the phase to -5.0.
`default_nettype none

module led_strip_wave_animator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [0] tick
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [31:0] m_axis_tdata,   // [4:0] led_index, [12:5] red,
	                                         // [20:13] green, [28:21] blue
	output      logic        m_axis_tlast,   // last_led
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import lswa_pkg::*;

	logic [9:0]  step_q;
	logic [12:0] period_q;
	logic [10:0] width_q;
	logic [15:0] inv_q;

	logic [STEP_W-1:0] upc_q;
	ctrl_t             ctrl;

	logic [15:0] phase_q;
	logic        neg_q;
	logic [13:0] dvd_q;
	logic [13:0] rem_q;
	logic [3:0]  cnt_q;
	logic [16:0] ratio_q;
	logic [12:0] diff_q;
	logic [16:0] inten_q;
	logic [33:0] prod_q;
	logic [LED_W-1:0] led_q;

	logic             out_valid_q;
	logic [LED_W-1:0] out_index_q;
	logic [7:0]       out_ch_q;
	logic             out_white_q;
	logic             out_last_q;

	logic        in_beat;
	logic        tick_go;
	logic        out_free;
	logic [16:0] sum;
	logic [16:0] sum_neg;
	logic [13:0] trial;
	logic        trial_ge;
	logic [12:0] rem13;
	logic [12:0] phase13;
	logic [12:0] wrapped;
	logic signed [14:0] dv;
	logic [14:0] dv_abs;
	logic [20:0] prod_hi;
	logic [20:0] inten_dif;
	logic [16:0] mul_a;
	logic [16:0] mul_b;
	logic [9:0]  seg_dist;

	assign ctrl          = ucode(upc_q);
	assign s_axis_tready = ctrl.in_ready;
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign tick_go       = in_beat && s_axis_tdata[0];
	assign out_free      = !out_valid_q || m_axis_tready;
	assign cfg_ready     = 1'b1;

	// signed phase plus step, magnitude for the bit-serial wrap
	assign sum     = {phase_q[15], phase_q} + {7'd0, step_q};
	assign sum_neg = 17'd0 - sum;

	assign trial    = {rem_q[12:0], dvd_q[DIV_BITS-1]};
	assign trial_ge = trial >= {1'b0, period_q};
	assign rem13    = rem_q[12:0];
	assign phase13  = phase_q[12:0];

	always_comb begin
		if (period_q == 13'd0) begin
			wrapped = 13'd0;
		end else if (neg_q && rem13 != 13'd0) begin
			wrapped = period_q - rem13;
		end else begin
			wrapped = rem13;
		end
	end

	// dist - (phase - width)
	assign seg_dist = led_dist(led_q);
	assign dv       = $signed({5'd0, seg_dist}) - $signed({2'd0, phase13})
	                + $signed({4'd0, width_q});
	assign dv_abs   = dv[14] ? 15'(-dv) : 15'(dv);

	assign prod_hi   = prod_q[28:8];
	assign inten_dif = 21'd65536 - prod_hi;

	always_comb begin
		case (ctrl.op)
			OP_MUL_RATIO: begin
				mul_a = {4'd0, phase13};
				mul_b = {1'b0, inv_q};
			end
			OP_MUL_DIFF: begin
				mul_a = {4'd0, diff_q};
				mul_b = {1'b0, inv_q};
			end
			OP_MUL_SCALE: begin
				mul_a = inten_q;
				mul_b = ratio_q;
			end
			default: begin
				mul_a = inten_q;
				mul_b = 17'd255;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= 10'd36;
			period_q <= 13'd2304;
			width_q  <= 11'd589;
			inv_q    <= 16'd28494;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PHASE_STEP:   step_q   <= cfg_data[9:0];
				CFG_PHASE_PERIOD: period_q <= cfg_data[12:0];
				CFG_WAVE_WIDTH:   width_q  <= cfg_data[10:0];
				CFG_INV_WIDTH:    inv_q    <= cfg_data;
			endcase
		end
	end

	// microcode sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_IDLE;
		end else begin
			unique case (ctrl.jmp)
				JMP_NEXT: upc_q <= upc_q + 4'd1;
				JMP_TICK: begin
					if (tick_go) begin
						upc_q <= upc_q + 4'd1;
					end
				end
				JMP_DIV: begin
					if (cnt_q == 4'(DIV_BITS - 1)) begin
						upc_q <= upc_q + 4'd1;
					end else begin
						upc_q <= ctrl.target;
					end
				end
				JMP_EMIT: begin
					if (out_free) begin
						upc_q <= (led_q == LED_LAST) ? STEP_IDLE : ctrl.target;
					end
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 16'hFB00;
			neg_q   <= 1'b0;
			dvd_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= 4'd0;
			ratio_q <= '0;
			diff_q  <= '0;
			inten_q <= '0;
			led_q   <= '0;
		end else begin
			case (ctrl.op)
				OP_IDLE: begin
					if (tick_go) begin
						neg_q <= sum[16];
						dvd_q <= sum[16] ? sum_neg[13:0] : sum[13:0];
						rem_q <= 14'd0;
						cnt_q <= 4'd0;
					end
				end
				OP_DIV: begin
					rem_q <= trial_ge ? trial - {1'b0, period_q} : trial;
					dvd_q <= {dvd_q[DIV_BITS-2:0], 1'b0};
					cnt_q <= cnt_q + 4'd1;
				end
				OP_FIX: begin
					phase_q <= {3'd0, wrapped};
					led_q   <= '0;
				end
				OP_RATIO: begin
					ratio_q <= (prod_hi > 21'd65536) ? 17'h10000 : prod_hi[16:0];
				end
				OP_DIFF: diff_q <= dv_abs[12:0];
				OP_INTEN: begin
					inten_q <= (prod_hi >= 21'd65536) ? 17'd0 : inten_dif[16:0];
				end
				OP_SCALE: begin
					if (phase13 < {2'd0, width_q}) begin
						inten_q <= prod_q[32:16];
					end
				end
				OP_EMIT: begin
					if (out_free && led_q != LED_LAST) begin
						led_q <= led_q + 5'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// shared multiplier, registered product
	always_ff @(posedge clk) begin
		if (ctrl.op == OP_MUL_RATIO || ctrl.op == OP_MUL_DIFF ||
		    ctrl.op == OP_MUL_SCALE || ctrl.op == OP_MUL_CH) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == OP_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_EMIT && out_free) begin
			out_index_q <= led_q;
			out_ch_q    <= prod_q[23:16];
			out_white_q <= led_white(led_q);
			out_last_q  <= (led_q == LED_LAST);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {3'd0,
	                        out_white_q ? out_ch_q : 8'd0,
	                        out_white_q ? out_ch_q : 8'd0,
	                        out_ch_q,
	                        out_index_q};

endmodule

`default_nettype wire
